/* rtl/core/sfrc_pkg.sv */
`default_nettype none

package sfrc_pkg;

	localparam logic [7:0] SOF_BYTE = 8'h98;
	localparam logic [7:0] EOF_BYTE = 8'h9C;
	localparam logic [7:0] ESC_BYTE = 8'h91;

	localparam logic [7:0] ESC_CODE_EOF = 8'h63;
	localparam logic [7:0] ESC_CODE_SOF = 8'h67;
	localparam logic [7:0] ESC_CODE_ESC = 8'h6E;

	localparam logic [15:0] CRC_POLY = 16'h90D9;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] KIND_PANEL_A = 8'h07;
	localparam logic [7:0] KIND_PANEL_B = 8'h09;

	localparam logic [2:0] RAW_MIN   = 3'd5;
	localparam logic [2:0] RAW_MAX   = 3'd7;
	localparam logic [3:0] DS_MAX    = 4'd15;
	localparam logic [3:0] DS_TAIL   = 4'd2;
	localparam logic [3:0] DS_HDR    = 4'd8;
	localparam logic [3:0] DS_FULL   = 4'd10;

	localparam int RESULT_W = 67;
	localparam int TDATA_W  = 72;

	typedef enum logic [1:0] {
		STATUS_GOOD  = 2'd0,
		STATUS_BAD   = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	typedef struct packed {
		logic        toward_heater;
		logic [31:0] payload_word;
		logic [15:0] message_code;
		logic [7:0]  packet_kind;
		logic [7:0]  dest_address;
		status_t     frame_status;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] b);
		logic [7:0] d;
		case (b)
			ESC_CODE_EOF: d = EOF_BYTE;
			ESC_CODE_SOF: d = SOF_BYTE;
			ESC_CODE_ESC: d = ESC_BYTE;
			default:      d = ESC_BYTE;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sfrc_engine.sv */
`default_nettype none

module sfrc_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              step,
	output logic                   result_valid,
	output sfrc_pkg::result_t      result
);

	logic        in_frame_q;
	logic        esc_q;
	logic [2:0]  raw_cnt_q;
	logic [3:0]  ds_cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  tail_q [2];
	logic [7:0]  hdr_q  [8];

	logic        is_sof;
	logic        is_eof;
	logic        is_esc;
	logic [7:0]  ds_byte;
	logic        take;
	logic [15:0] rx_crc;

	assign is_sof  = (rx_byte == sfrc_pkg::SOF_BYTE);
	assign is_eof  = (rx_byte == sfrc_pkg::EOF_BYTE);
	assign is_esc  = (rx_byte == sfrc_pkg::ESC_BYTE);
	assign ds_byte = esc_q ? sfrc_pkg::unescape(rx_byte) : rx_byte;
	assign take    = step && in_frame_q && !is_sof && !is_eof && !is_esc;
	assign rx_crc  = {tail_q[0], tail_q[1]};

	assign result_valid = item_valid && is_eof && in_frame_q && (raw_cnt_q >= sfrc_pkg::RAW_MIN);

	always_comb begin
		result = '0;
		if (ds_cnt_q < sfrc_pkg::DS_TAIL || rx_crc != crc_q) begin
			result.frame_status = sfrc_pkg::STATUS_BAD;
		end else if (ds_cnt_q < sfrc_pkg::DS_FULL) begin
			result.frame_status = sfrc_pkg::STATUS_SHORT;
		end else begin
			result.frame_status  = sfrc_pkg::STATUS_GOOD;
			result.dest_address  = hdr_q[0];
			result.packet_kind   = hdr_q[1];
			result.message_code  = {hdr_q[2], hdr_q[3]};
			result.payload_word  = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
			result.toward_heater = (hdr_q[1] == sfrc_pkg::KIND_PANEL_A) ||
				(hdr_q[1] == sfrc_pkg::KIND_PANEL_B);
		end
	end

	// frame control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			raw_cnt_q  <= '0;
			ds_cnt_q   <= '0;
			crc_q      <= sfrc_pkg::CRC_INIT;
		end else if (step) begin
			if (is_sof || is_eof) begin
				in_frame_q <= is_sof;
				esc_q      <= 1'b0;
				raw_cnt_q  <= '0;
				ds_cnt_q   <= '0;
				crc_q      <= sfrc_pkg::CRC_INIT;
			end else if (in_frame_q) begin
				if (raw_cnt_q != sfrc_pkg::RAW_MAX) begin
					raw_cnt_q <= raw_cnt_q + 3'd1;
				end
				if (is_esc) begin
					esc_q <= 1'b1;
				end else begin
					esc_q <= 1'b0;
					if (ds_cnt_q >= sfrc_pkg::DS_TAIL) begin
						crc_q <= sfrc_pkg::crc_byte(crc_q, tail_q[0]);
					end
					if (ds_cnt_q != sfrc_pkg::DS_MAX) begin
						ds_cnt_q <= ds_cnt_q + 4'd1;
					end
				end
			end
		end
	end

	// byte stores
	always_ff @(posedge clk) begin
		if (take) begin
			if (ds_cnt_q < sfrc_pkg::DS_HDR) begin
				hdr_q[ds_cnt_q[2:0]] <= ds_byte;
			end
			if (ds_cnt_q >= sfrc_pkg::DS_TAIL) begin
				tail_q[0] <= tail_q[1];
				tail_q[1] <= ds_byte;
			end else begin
				tail_q[ds_cnt_q[0]] <= ds_byte;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sfrc_out_queue.sv */
`default_nettype none

module sfrc_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sfrc_pkg::result_t push_data,
	output logic                   full,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output sfrc_pkg::result_t      pop_data
);

	sfrc_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/stuffed_frame_receiver_crc16_unit.sv */
// a closing byte's result passes through the input register, then the result queue, before m_tvalid shows it
// throughput: one byte per cycle; ready drops only while a closing byte waits on a full
// two-entry result queue
// reset: arst_n clears frame state, crc to 0xffff, the input valid flag and the result queue;
// byte stores are not reset
`default_nettype none

module stuffed_frame_receiver_crc16_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // rx_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// frame_status, dest_address, packet_kind, message_code, payload_word, toward_heater, zeros
	output logic [sfrc_pkg::TDATA_W-1:0]       m_tdata
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              emit;
	logic              q_full;
	sfrc_pkg::result_t eng_result;
	sfrc_pkg::result_t out_result;

	assign advance  = valid_s1 && (!emit || !q_full);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	sfrc_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.rx_byte      (byte_s1),
		.step         (advance),
		.result_valid (emit),
		.result       (eng_result)
	);

	sfrc_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && emit),
		.push_data (eng_result),
		.full      (q_full),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_data  (out_result)
	);

	assign m_tdata = {{(sfrc_pkg::TDATA_W - sfrc_pkg::RESULT_W){1'b0}}, out_result};

	assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && emit && q_full))
		else $error("result pushed into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_result.frame_status != sfrc_pkg::STATUS_GOOD) |->
		(out_result.dest_address == 8'h00 && out_result.payload_word == 32'h0 &&
		 out_result.message_code == 16'h0 && !out_result.toward_heater))
		else $error("bad frame carries payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && !m_tvalid) |=> m_tvalid)
		else $error("result not presented");

endmodule

`default_nettype wire
